@@ design/base58_string_decoder_top_macros.svh @@
// assertion macros for the base58 string decoder
`ifndef BASE58_STRING_DECODER_TOP_MACROS_SVH
`define BASE58_STRING_DECODER_TOP_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define B58_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define B58_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/b58_pkg.sv @@
// shared types, constants and helper functions of the base58 string decoder
package b58_pkg;

  localparam int MaxChars    = 64;
  localparam int NumberBytes = 48;
  localparam int ResultLimit = 64;

  localparam int IdxW  = (NumberBytes > 1) ? $clog2(NumberBytes) : 1;
  localparam int CntW  = $clog2(NumberBytes + 1);
  localparam int CharW = 7;
  localparam int OnesW = 7;
  localparam int TotW  = OnesW + 1;
  localparam int NW    = $clog2(ResultLimit + 1);
  localparam int ProdW = 14;
  localparam int DigW  = 6;

  localparam logic [CharW-1:0] CharSat  = 7'd127;
  localparam logic [OnesW-1:0] OnesSat  = 7'd127;
  localparam logic [7:0]       AsciiOne = 8'h31;
  localparam logic [7:0]       AsciiNul = 8'h00;
  localparam logic [7:0]       Radix    = 8'd58;

  typedef enum logic [1:0] {
    PH_LEAD   = 2'd0,
    PH_ONES   = 2'd1,
    PH_DIGITS = 2'd2,
    PH_TRAIL  = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    CODE_OK      = 3'd0,
    CODE_INVALID = 3'd1,
    CODE_GARBAGE = 3'd2,
    CODE_LONG    = 3'd3,
    CODE_NUL     = 3'd4
  } code_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_FINISH,
    ST_EMIT_RD,
    ST_EMIT_WR
  } state_e;

  typedef struct packed {
    logic accept;
    logic mul_step;
    logic emit_addr;
    logic beat_load;
    logic single_load;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic item_digit;
    logic item_eos;
    logic eos_held;
    logic mul_last;
    logic single;
    logic out_free;
    logic beat_last;
  } sts_t;

  typedef struct packed {
    logic            ok;
    logic [DigW-1:0] val;
  } digit_t;

  function automatic logic is_space(logic [7:0] c);
    return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  // bitcoin alphabet: no 0, I, O or l
  function automatic digit_t digit_decode(logic [7:0] c);
    digit_t     res;
    logic [7:0] off;
    res = '0;
    off = '0;
    if ((c >= 8'h31) && (c <= 8'h39)) begin
      off = c - 8'h31;
      res.ok = 1'b1;
    end else if ((c >= 8'h41) && (c <= 8'h48)) begin
      off = c - 8'h41 + 8'd9;
      res.ok = 1'b1;
    end else if ((c >= 8'h4a) && (c <= 8'h4e)) begin
      off = c - 8'h4a + 8'd17;
      res.ok = 1'b1;
    end else if ((c >= 8'h50) && (c <= 8'h5a)) begin
      off = c - 8'h50 + 8'd22;
      res.ok = 1'b1;
    end else if ((c >= 8'h61) && (c <= 8'h6b)) begin
      off = c - 8'h61 + 8'd33;
      res.ok = 1'b1;
    end else if ((c >= 8'h6d) && (c <= 8'h7a)) begin
      off = c - 8'h6d + 8'd44;
      res.ok = 1'b1;
    end
    res.val = off[DigW-1:0];
    return res;
  endfunction

  // too long beats everything, nul beats invalid and garbage, else first wins
  function automatic code_e merge_error(code_e cur, code_e code);
    code_e res;
    res = cur;
    if (cur != CODE_LONG) begin
      if ((code == CODE_LONG) || ((code == CODE_NUL) && (cur != CODE_NUL)) ||
          (cur == CODE_OK)) begin
        res = code;
      end
    end
    return res;
  endfunction

endpackage

@@ design/b58_ctrl.sv @@
// controller state machine of the base58 string decoder
module b58_ctrl
  import b58_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_ready_o,
  input  sts_t   sts_i,
  output cmd_t   cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (sts_i.item_digit) begin
            state_d = ST_MUL;
          end else if (sts_i.item_eos) begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_MUL: begin
        if (sts_i.mul_last) begin
          state_d = sts_i.eos_held ? ST_FINISH : ST_IDLE;
        end
      end
      ST_FINISH: begin
        if (!sts_i.single) begin
          state_d = ST_EMIT_RD;
        end else if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_EMIT_RD: state_d = ST_EMIT_WR;
      ST_EMIT_WR: begin
        if (sts_i.out_free) begin
          state_d = sts_i.beat_last ? ST_IDLE : ST_EMIT_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.accept  = in_valid_i;
      end
      ST_MUL: cmd_o.mul_step = 1'b1;
      ST_FINISH: begin
        if (sts_i.single && sts_i.out_free) begin
          cmd_o.single_load = 1'b1;
          cmd_o.clear       = 1'b1;
        end
      end
      ST_EMIT_RD: cmd_o.emit_addr = 1'b1;
      ST_EMIT_WR: begin
        cmd_o.emit_addr = 1'b1;
        if (sts_i.out_free) begin
          cmd_o.beat_load = 1'b1;
          cmd_o.clear     = sts_i.beat_last;
        end
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

@@ design/b58_datapath.sv @@
// scan registers, number memory, multiply-add step and output register
module b58_datapath
  import b58_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] char_code_i,
  input  logic       char_present_i,
  input  logic       end_of_string_i,
  input  cmd_t       cmd_i,
  output sts_t       sts_o,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  output logic [7:0] out_data_o,
  output logic [3:0] out_user_o,
  output logic       out_last_o
);

  // scan state
  phase_e           phase_q, phase_d;
  logic [OnesW-1:0] ones_q, ones_d;
  logic [CharW-1:0] chars_q, chars_d;
  code_e            err_q, err_d;
  logic [CntW-1:0]  use_q;
  logic             eos_q;
  logic             start_mul;
  digit_t           dig;

  // multiply-add walk
  logic [IdxW-1:0]  idx_q;
  logic [DigW-1:0]  carry_q;
  logic [CntW-1:0]  new_use_q;
  logic [7:0]       rbyte;
  logic [ProdW-1:0] prod;
  logic             mul_last;

  // number memory, index 0 least significant
  logic [7:0]       num_mem [NumberBytes];
  logic [7:0]       rdata_q;
  logic [IdxW-1:0]  raddr;

  // emission
  logic [NW-1:0]    n_q;
  logic [TotW-1:0]  total;
  logic [NW-1:0]    tot_clamp;
  logic             n_is_one;
  logic [TotW-1:0]  emit_pos;

  logic             out_valid_q;
  logic [7:0]       out_data_q;
  logic [3:0]       out_user_q;
  logic             out_last_q;
  logic             out_free;

  // per-character scan
  always_comb begin
    phase_d   = phase_q;
    ones_d    = ones_q;
    chars_d   = chars_q;
    err_d     = err_q;
    start_mul = 1'b0;
    dig       = digit_decode(char_code_i);
    if (char_present_i) begin
      if (chars_q != CharSat) begin
        chars_d = chars_q + 1'b1;
      end
      if (chars_d > CharW'(MaxChars)) begin
        err_d = merge_error(err_d, CODE_LONG);
      end
      if (char_code_i == AsciiNul) begin
        err_d = merge_error(err_d, CODE_NUL);
      end else if (err_d == CODE_OK) begin
        if (phase_q == PH_TRAIL) begin
          if (!is_space(char_code_i)) begin
            err_d = merge_error(err_d, CODE_GARBAGE);
          end
        end else if (is_space(char_code_i)) begin
          if (phase_q != PH_LEAD) begin
            phase_d = PH_TRAIL;
          end
        end else if ((char_code_i == AsciiOne) && (phase_q != PH_DIGITS)) begin
          if (ones_q != OnesSat) begin
            ones_d = ones_q + 1'b1;
          end
          phase_d = PH_ONES;
        end else if (!dig.ok) begin
          err_d = merge_error(err_d, CODE_INVALID);
        end else begin
          phase_d   = PH_DIGITS;
          start_mul = 1'b1;
        end
      end
    end
  end

  // bytes at or above the fill count read as zero
  assign rbyte    = (CntW'(idx_q) < use_q) ? rdata_q : 8'd0;
  assign prod     = ProdW'(rbyte) * ProdW'(Radix) + ProdW'(carry_q);
  assign mul_last = (CntW'(idx_q) == use_q) || (idx_q == IdxW'(NumberBytes - 1));

  assign total     = TotW'(ones_q) + TotW'(use_q);
  assign tot_clamp = (total > TotW'(ResultLimit)) ? NW'(ResultLimit) : NW'(total);
  assign n_is_one  = TotW'(n_q) < TotW'(ones_q);
  assign emit_pos  = total - TotW'(1) - TotW'(n_q);

  always_comb begin
    raddr = '0;
    if (cmd_i.mul_step) begin
      raddr = mul_last ? '0 : idx_q + 1'b1;
    end else if (cmd_i.emit_addr && !n_is_one) begin
      raddr = emit_pos[IdxW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_step) begin
      num_mem[idx_q] <= prod[7:0];
    end
    rdata_q <= num_mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_LEAD;
      ones_q    <= '0;
      chars_q   <= '0;
      err_q     <= CODE_OK;
      use_q     <= '0;
      eos_q     <= 1'b0;
      idx_q     <= '0;
      carry_q   <= '0;
      new_use_q <= '0;
      n_q       <= '0;
    end else begin
      if (cmd_i.accept) begin
        phase_q   <= phase_d;
        ones_q    <= ones_d;
        chars_q   <= chars_d;
        err_q     <= err_d;
        eos_q     <= end_of_string_i;
        idx_q     <= '0;
        carry_q   <= dig.val;
        new_use_q <= '0;
      end
      if (cmd_i.mul_step) begin
        idx_q   <= idx_q + 1'b1;
        carry_q <= prod[ProdW-1:8];
        if (prod[7:0] != 8'd0) begin
          new_use_q <= CntW'(idx_q) + 1'b1;
        end
        if (mul_last) begin
          use_q <= (prod[7:0] != 8'd0) ? CntW'(idx_q) + 1'b1 : new_use_q;
        end
      end
      // beat counter restarts with the string
      if (cmd_i.clear) begin
        n_q <= '0;
      end else if (cmd_i.beat_load) begin
        n_q <= n_q + 1'b1;
      end
      if (cmd_i.clear) begin
        phase_q <= PH_LEAD;
        ones_q  <= '0;
        chars_q <= '0;
        err_q   <= CODE_OK;
        use_q   <= '0;
      end
    end
  end

  // output register
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.beat_load || cmd_i.single_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.beat_load) begin
      out_data_q <= n_is_one ? 8'd0 : rdata_q;
      out_user_q <= {CODE_OK, 1'b1};
      out_last_q <= sts_o.beat_last;
    end else if (cmd_i.single_load) begin
      out_data_q <= 8'd0;
      out_user_q <= {err_q, 1'b0};
      out_last_q <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_user_o  = out_user_q;
  assign out_last_o  = out_last_q;

  assign sts_o.item_digit = start_mul;
  assign sts_o.item_eos   = end_of_string_i;
  assign sts_o.eos_held   = eos_q;
  assign sts_o.mul_last   = mul_last;
  assign sts_o.single     = (err_q != CODE_OK) || (total == '0);
  assign sts_o.out_free   = out_free;
  assign sts_o.beat_last  = ((n_q + 1'b1) == tot_clamp);

endmodule

@@ design/base58_string_decoder_top.sv @@
// top level of the base58 string decoder, bitcoin alphabet
//
// Takes one character per input beat and decodes the string when the beat with
// tlast arrives. Leading whitespace is skipped, each leading '1' yields a zero
// byte, and every later alphabet digit updates a big number held in a 48-byte
// memory as number*58+digit. Trailing whitespace is allowed. At string end the
// block sends the zero bytes and then the significant bytes, most significant
// first, or one error beat (too long > nul > first of invalid char/trailing garbage);
// an empty or all-blank string gives one beat with byte_valid low and status ok.
// A digit starts a multiply-add walk over min(significant bytes + 1, 48) bytes,
// one byte per cycle through the single read port of the number memory. At the
// end of a string the block loads a single status beat, or for each byte beat
// reads the memory and then loads the output register; each load waits while
// the output register holds a beat that tready has not taken.
// One string is worked on at a time; the
// next string's first beat is taken while the final output beat still waits in
// the output register. The number store is tracked by a fill count, so no
// clearing pass is needed after reset or between strings.
module base58_string_decoder_top
  import b58_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  // input beats: one character each
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] char_code
  input  logic       s_axis_tuser,   // [0] char_present
  input  logic       s_axis_tlast,   // end_of_string
  // output beats: decoded bytes or one status beat
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] data_byte
  output logic [3:0] m_axis_tuser,   // [0] byte_valid, [3:1] status
  output logic       m_axis_tlast    // last_byte
);

  cmd_t cmd;
  sts_t sts;

  // sequencing: accept, multiply-add walk, finish, emission
  b58_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // scan state, number memory and output register
  b58_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .char_code_i     (s_axis_tdata),
    .char_present_i  (s_axis_tuser),
    .end_of_string_i (s_axis_tlast),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_ready_i     (m_axis_tready),
    .out_valid_o     (m_axis_tvalid),
    .out_data_o      (m_axis_tdata),
    .out_user_o      (m_axis_tuser),
    .out_last_o      (m_axis_tlast)
  );

`include "base58_string_decoder_top_macros.svh"

  // a beat without a decoded byte always closes the string
  `B58_ASSERT_NOW(a_nobyte_is_last, m_axis_tvalid && !m_axis_tuser[0], m_axis_tlast, "non-byte beat without tlast")

  // an error beat carries no byte
  `B58_ASSERT_NOW(a_error_no_byte, m_axis_tvalid && (m_axis_tuser[3:1] != 3'd0), !m_axis_tuser[0] && (m_axis_tdata == 8'd0), "error beat carries data")

  // no input is taken while the number is being walked or a result is loaded
  `B58_ASSERT_NOW(a_ready_exclusive, s_axis_tready, !(cmd.mul_step || cmd.beat_load || cmd.single_load), "input ready during busy phase")

  // the last multiply-add step hands control back or finishes the string
  `B58_ASSERT_NEXT(a_mul_ends, cmd.mul_step && sts.mul_last, !cmd.mul_step, "multiply walk overran")

endmodule
